@@ hdl/lkst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkst_pkg: shared types and constants for the LRU key-to-slot table
// Default sizes, fixed port widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package lkst_pkg;

    localparam int DEF_SLOTS      = 16;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_STAMP_BITS = 32;

    // Fixed port widths
    localparam int IN_KEY_BITS   = 32;
    localparam int IDX_OUT_BITS  = 4;
    localparam int RKEY_OUT_BITS = 32;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;    // capture request, clear trackers, reset scan address
        logic rd;      // read slot at scan address, advance address
        logic commit;  // update table, load result word
    } t_ctl_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic last_addr;  // scan address is at the final slot
        logic out_free;   // result register can take a word this cycle
    } t_ctl_sts;

endpackage

@@ hdl/lkst_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkst_ctrl: sequencer for the LRU key-to-slot table
// Accept, scan all slots, drain the read pipeline, then commit the result.
// ----------------------------------------------------------------------------
module lkst_ctrl
    import lkst_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_ctl_sts i_sts,
    output t_ctl_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } t_state;

    t_state r_state;
    logic   r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && r_ready) begin
                        r_state <= S_SCAN;
                        r_ready <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (i_sts.last_addr) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_ready <= 1'b1;
                end
            endcase
        end
    end

    assign o_ready = r_ready;

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == S_IDLE) && i_valid && r_ready;
        o_cmd.rd     = (r_state == S_SCAN);
        o_cmd.commit = (r_state == S_COMMIT) && i_sts.out_free;
    end

endmodule

@@ hdl/lkst_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkst_datapath: slot storage, scan trackers and result register
// Key and stamp memories are read one slot per cycle; one write at commit.
// ----------------------------------------------------------------------------
module lkst_datapath
    import lkst_pkg::*;
#(
    parameter int SLOTS      = DEF_SLOTS,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int STAMP_BITS = DEF_STAMP_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [IN_KEY_BITS-1:0]   i_key,
    input  logic                     i_create,
    input  t_ctl_cmd                 i_cmd,
    output t_ctl_sts                 o_sts,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_hit,
    output logic                     o_slot_valid,
    output logic [IDX_OUT_BITS-1:0]  o_slot_index,
    output logic                     o_replaced,
    output logic [RKEY_OUT_BITS-1:0] o_replaced_key
);

    localparam int IW = $clog2(SLOTS);
    localparam logic [STAMP_BITS-1:0] STAMP_MAX = {STAMP_BITS{1'b1}};

    // slot storage
    logic [KEY_BITS-1:0]   r_key_mem   [SLOTS];
    logic [STAMP_BITS-1:0] r_stamp_mem [SLOTS];
    logic [SLOTS-1:0]      r_live;
    logic [STAMP_BITS-1:0] r_count;

    // request
    logic [KEY_BITS-1:0]   r_key;
    logic                  r_create;
    logic [KEY_BITS-1:0]   w_key_in;

    // scan pipeline
    logic [IW-1:0]         r_addr;
    logic [IW-1:0]         r_cmp_idx;
    logic                  r_cmp_en;
    logic [KEY_BITS-1:0]   r_rd_key;
    logic [STAMP_BITS-1:0] r_rd_stamp;

    // trackers
    logic                  r_hit;
    logic [IW-1:0]         r_hit_idx;
    logic                  r_have_free;
    logic [IW-1:0]         r_free_idx;
    logic [IW-1:0]         r_min_idx;
    logic [STAMP_BITS-1:0] r_min_stamp;
    logic [KEY_BITS-1:0]   r_min_key;

    // result register
    logic                     r_out_valid;
    logic                     r_out_hit;
    logic                     r_out_slot_valid;
    logic [IDX_OUT_BITS-1:0]  r_out_idx;
    logic                     r_out_repl;
    logic [RKEY_OUT_BITS-1:0] r_out_rkey;

    // commit decode
    logic                     w_key_nz;
    logic                     w_alloc;
    logic                     w_repl;
    logic [IW-1:0]            w_pick;
    logic [IW-1:0]            w_sel_idx;
    logic [IDX_OUT_BITS-1:0]  w_sel_idx_out;
    logic [RKEY_OUT_BITS-1:0] w_min_key_out;
    logic [STAMP_BITS-1:0]    w_next_stamp;

    generate
        if (KEY_BITS <= IN_KEY_BITS) begin : g_key_trunc
            assign w_key_in = i_key[KEY_BITS-1:0];
        end else begin : g_key_ext
            assign w_key_in = {{(KEY_BITS-IN_KEY_BITS){1'b0}}, i_key};
        end
        if (KEY_BITS >= RKEY_OUT_BITS) begin : g_rkey_trunc
            assign w_min_key_out = r_min_key[RKEY_OUT_BITS-1:0];
        end else begin : g_rkey_ext
            assign w_min_key_out = {{(RKEY_OUT_BITS-KEY_BITS){1'b0}}, r_min_key};
        end
        if (IW >= IDX_OUT_BITS) begin : g_idx_trunc
            assign w_sel_idx_out = w_sel_idx[IDX_OUT_BITS-1:0];
        end else begin : g_idx_ext
            assign w_sel_idx_out = {{(IDX_OUT_BITS-IW){1'b0}}, w_sel_idx};
        end
    endgenerate

    assign w_key_nz     = (r_key != '0);
    assign w_alloc      = !r_hit && r_create && w_key_nz;
    assign w_repl       = w_alloc && !r_have_free;
    assign w_pick       = r_have_free ? r_free_idx : r_min_idx;
    assign w_sel_idx    = r_hit ? r_hit_idx : w_pick;
    assign w_next_stamp = (r_count != STAMP_MAX) ? r_count + 1'b1 : r_count;

    assign o_sts.last_addr = (r_addr == IW'(SLOTS - 1));
    assign o_sts.out_free  = !r_out_valid || i_ready;

    // memory read and write ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_key   <= r_key_mem[r_addr];
            r_rd_stamp <= r_stamp_mem[r_addr];
        end
        if (i_cmd.commit && w_alloc) begin
            r_key_mem[w_pick] <= r_key;
        end
        if (i_cmd.commit && (r_hit || w_alloc)) begin
            r_stamp_mem[w_sel_idx] <= w_next_stamp;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live      <= '0;
            r_count     <= '0;
            r_cmp_en    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmp_en <= i_cmd.rd;
            if (i_cmd.commit) begin
                if (w_alloc) begin
                    r_live[w_pick] <= 1'b1;
                end
                if (r_hit || w_alloc) begin
                    r_count <= w_next_stamp;
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request capture, scan address and trackers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key       <= w_key_in;
            r_create    <= i_create;
            r_addr      <= '0;
            r_hit       <= 1'b0;
            r_have_free <= 1'b0;
        end else begin
            if (i_cmd.rd) begin
                r_cmp_idx <= r_addr;
                if (!o_sts.last_addr) begin
                    r_addr <= r_addr + 1'b1;
                end
            end
            if (r_cmp_en) begin
                if (!r_hit && r_live[r_cmp_idx] && (r_rd_key == r_key) && w_key_nz) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_cmp_idx;
                end
                if (!r_have_free && !r_live[r_cmp_idx]) begin
                    r_have_free <= 1'b1;
                    r_free_idx  <= r_cmp_idx;
                end
                // strict less-than keeps the lowest index on a tie
                if ((r_cmp_idx == '0) || (r_rd_stamp < r_min_stamp)) begin
                    r_min_idx   <= r_cmp_idx;
                    r_min_stamp <= r_rd_stamp;
                    r_min_key   <= r_rd_key;
                end
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_hit        <= r_hit;
            r_out_slot_valid <= r_hit || w_alloc;
            r_out_idx        <= (r_hit || w_alloc) ? w_sel_idx_out : '0;
            r_out_repl       <= w_repl;
            r_out_rkey       <= w_repl ? w_min_key_out : '0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_hit          = r_out_hit;
    assign o_slot_valid   = r_out_slot_valid;
    assign o_slot_index   = r_out_idx;
    assign o_replaced     = r_out_repl;
    assign o_replaced_key = r_out_rkey;

endmodule

@@ hdl/lru_key_slot_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_slot_table: fully associative key-to-slot table, LRU replacement
// Looks up a key, optionally allocates a slot, reports the slot and victim.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_valid / o_ready) carries one word: i_key, i_create.
//   Result channel (o_valid / i_ready) returns exactly one word per request:
//   o_hit, o_slot_valid, o_slot_index, o_replaced, o_replaced_key.
//   A zero key never matches and is never stored; its result is all zero.
// Timing:
//   After a request is taken the controller scans every slot, one per cycle,
//   through the key and stamp memories (one read port each, registered data).
//   The scan finds the hit, the first free slot and the oldest stamp in one
//   pass. The result word is registered at commit, after the scan and drain;
//   one request is scanned at a time, and the next is taken after a commit.
// Reset:
//   Synchronous, active low. All slots become free and the use counter is
//   cleared; no clearing pass is needed, memory contents of free slots are
//   never used.
// Stall:
//   The result sits in an output register until taken. The next request is
//   accepted meanwhile and scanned; its commit waits for the register.
// ----------------------------------------------------------------------------
module lru_key_slot_table
    import lkst_pkg::*;
#(
    parameter int SLOTS      = DEF_SLOTS,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int STAMP_BITS = DEF_STAMP_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request channel
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [IN_KEY_BITS-1:0]   i_key,
    input  logic                     i_create,
    // result channel
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_hit,
    output logic                     o_slot_valid,
    output logic [IDX_OUT_BITS-1:0]  o_slot_index,
    output logic                     o_replaced,
    output logic [RKEY_OUT_BITS-1:0] o_replaced_key
);

    t_ctl_cmd w_cmd;
    t_ctl_sts w_sts;

    // sequencer: idle -> scan -> drain -> commit
    lkst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // storage, trackers and the result register
    lkst_datapath #(
        .SLOTS      (SLOTS),
        .KEY_BITS   (KEY_BITS),
        .STAMP_BITS (STAMP_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_key          (i_key),
        .i_create       (i_create),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_hit          (o_hit),
        .o_slot_valid   (o_slot_valid),
        .o_slot_index   (o_slot_index),
        .o_replaced     (o_replaced),
        .o_replaced_key (o_replaced_key)
    );

    // a commit never overwrites a result word still waiting
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> w_sts.out_free)
        else $error("commit while result register occupied");

    // block goes busy right after taking a request
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready still high after accept");

    // a new result word only comes from a commit
    a_valid_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_cmd.commit))
        else $error("result valid without commit");

    // load and scan read never overlap
    a_load_not_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> !w_cmd.rd)
        else $error("load during scan");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for lru_key_slot_table
// Streams lookup/create words through the request channel with random gaps
// and result back-pressure. An in-bench model of the slot table predicts
// every result word, which is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;
    import lkst_pkg::*;

    localparam int TBL_SLOTS  = DEF_SLOTS;
    localparam int KEY_W      = DEF_KEY_BITS;
    localparam int STAMP_W    = DEF_STAMP_BITS;
    localparam int LATENCY    = TBL_SLOTS + 3;
    localparam int RAND_ITEMS = 400;
    localparam int POOL       = 24;        // more keys than slots: forces evictions
    localparam int LIMIT      = 200000;    // cycles

    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

    typedef struct packed {
        logic [IN_KEY_BITS-1:0] key;
        logic                   create;
    } t_lookup;

    typedef struct packed {
        logic                     hit;
        logic                     slot_valid;
        logic [IDX_OUT_BITS-1:0]  slot_index;
        logic                     replaced;
        logic [RKEY_OUT_BITS-1:0] replaced_key;
    } t_slot_result;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    logic [IN_KEY_BITS-1:0]   i_key;
    logic                     i_create;
    logic                     o_valid;
    logic                     i_ready;
    logic                     o_hit;
    logic                     o_slot_valid;
    logic [IDX_OUT_BITS-1:0]  o_slot_index;
    logic                     o_replaced;
    logic [RKEY_OUT_BITS-1:0] o_replaced_key;

    lru_key_slot_table #(
        .SLOTS      (TBL_SLOTS),
        .KEY_BITS   (KEY_W),
        .STAMP_BITS (STAMP_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_key          (i_key),
        .i_create       (i_create),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_hit          (o_hit),
        .o_slot_valid   (o_slot_valid),
        .o_slot_index   (o_slot_index),
        .o_replaced     (o_replaced),
        .o_replaced_key (o_replaced_key)
    );

    // Shadow copy of the slot table
    logic               tbl_live  [TBL_SLOTS];
    logic [KEY_W-1:0]   tbl_key   [TBL_SLOTS];
    logic [STAMP_W-1:0] tbl_stamp [TBL_SLOTS];
    logic [STAMP_W-1:0] use_count;

    t_lookup      pending_lookups[$];
    t_slot_result expected_slots[$];
    t_lookup      next_lookup;
    t_slot_result got;
    t_slot_result want;

    int  err_count   = 0;
    int  cycle_count = 0;
    int  req_wait    = 0;
    int  rsp_wait    = 0;
    int  rsp_draw    = 0;
    int  phase_left  = 0;
    logic calm       = 1'b0;   // stretch with no idling on either side
    logic req_fire   = 1'b0;
    logic rsp_fire   = 1'b0;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic [STAMP_W-1:0] bump_use_count();
        if (use_count != STAMP_MAX)
            use_count = use_count + 1'b1;
        return use_count;
    endfunction

    function automatic t_slot_result slot_lookup(input logic [IN_KEY_BITS-1:0] key_in,
                                                 input logic create);
        t_slot_result     r;
        logic [KEY_W-1:0] k;
        int               hit_at;
        int               free_at;
        r       = '0;
        k       = key_in[KEY_W-1:0];
        hit_at  = -1;
        free_at = -1;
        if (k == '0)
            return r;              // zero key: never matches, never stored
        for (int i = 0; i < TBL_SLOTS; i++) begin
            if (hit_at < 0 && tbl_live[i] && tbl_key[i] == k)
                hit_at = i;
            if (free_at < 0 && !tbl_live[i])
                free_at = i;
        end
        if (hit_at >= 0) begin
            tbl_stamp[hit_at] = bump_use_count();
            r.hit        = 1'b1;
            r.slot_valid = 1'b1;
            r.slot_index = IDX_OUT_BITS'(hit_at);
            return r;
        end
        if (!create)
            return r;
        if (free_at < 0) begin
            // table full: evict oldest stamp, strict compare keeps lowest index on ties
            free_at = 0;
            for (int i = 1; i < TBL_SLOTS; i++)
                if (tbl_stamp[i] < tbl_stamp[free_at])
                    free_at = i;
            r.replaced     = 1'b1;
            r.replaced_key = tbl_key[free_at];
        end
        tbl_live[free_at]  = 1'b1;
        tbl_key[free_at]   = k;
        tbl_stamp[free_at] = bump_use_count();
        r.slot_valid = 1'b1;
        r.slot_index = IDX_OUT_BITS'(free_at);
        return r;
    endfunction

    task automatic compare_field(input string what, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, what, exp_val, act_val);
            err_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_lookup(input logic [IN_KEY_BITS-1:0] key_in, input logic create);
        t_lookup t;
        t.key    = key_in;
        t.create = create;
        pending_lookups.push_back(t);
    endtask

    function automatic logic [IN_KEY_BITS-1:0] fresh_key();
        logic [IN_KEY_BITS-1:0] k;
        k = $urandom;
        return (k == '0) ? 1 : k;
    endfunction

    function automatic int pick_wait();
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    // Alternate between idling and no-idling stretches
    always @(negedge i_clk) begin
        if (phase_left == 0) begin
            calm       <= ($urandom_range(0, 3) == 0);
            phase_left <= $urandom_range(40, 200);
        end else begin
            phase_left <= phase_left - 1;
        end
    end

    // ------------------------------------------------------------------------
    // Request driver: holds each word until accepted, then idles a drawn gap
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || req_fire)) begin
            if (req_wait > 0) begin
                req_wait <= req_wait - 1;
                i_valid  <= 1'b0;
                i_key    <= $urandom;      // junk on idle cycles must be ignored
                i_create <= 1'($urandom_range(0, 1));
            end else if (pending_lookups.size() > 0) begin
                next_lookup = pending_lookups.pop_front();
                i_valid  <= 1'b1;
                i_key    <= next_lookup.key;
                i_create <= next_lookup.create;
                req_wait <= pick_wait();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result side: stall a drawn number of cycles after each taken word
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_fire) begin
                rsp_draw = pick_wait();
                i_ready  <= (rsp_draw == 0);
                rsp_wait <= (rsp_draw == 0) ? 0 : rsp_draw - 1;
            end else if (rsp_wait > 0) begin
                rsp_wait <= rsp_wait - 1;
                i_ready  <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on request accept, check on result accept
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_fire <= 1'b0;
            rsp_fire <= 1'b0;
        end else begin
            req_fire <= i_valid && o_ready;
            rsp_fire <= o_valid && i_ready;
            if (i_valid && o_ready)
                expected_slots.push_back(slot_lookup(i_key, i_create));
            if (o_valid && i_ready) begin
                got = {o_hit, o_slot_valid, o_slot_index, o_replaced, o_replaced_key};
                if (expected_slots.size() == 0) begin
                    $display("%0t ns: result word with none expected, expected none, actual %h",
                             $time, got);
                    err_count++;
                end else begin
                    want = expected_slots.pop_front();
                    compare_field("hit", 32'(want.hit), 32'(got.hit));
                    compare_field("slot_valid", 32'(want.slot_valid), 32'(got.slot_valid));
                    compare_field("slot_index", 32'(want.slot_index), 32'(got.slot_index));
                    compare_field("replaced", 32'(want.replaced), 32'(got.replaced));
                    compare_field("replaced_key", want.replaced_key, got.replaced_key);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed words, random words, drain, verdict
    // ------------------------------------------------------------------------
    initial begin
        logic [IN_KEY_BITS-1:0] key_pool [POOL];
        int                     span;
        int                     sel;

        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_key    = '0;
        i_create = 1'b0;
        i_ready  = 1'b0;
        use_count = '0;
        for (int i = 0; i < TBL_SLOTS; i++) begin
            tbl_live[i]  = 1'b0;
            tbl_key[i]   = '0;
            tbl_stamp[i] = '0;
        end

        // directed: zero key both ways, lookup miss, fill, hit, LRU eviction
        queue_lookup('0, 1'b0);
        queue_lookup('0, 1'b1);
        queue_lookup(32'h0000_0001, 1'b0);
        queue_lookup(32'hFFFF_FFFF, 1'b1);
        queue_lookup(32'h0000_0001, 1'b1);
        queue_lookup(32'hFFFF_FFFF, 1'b0);    // hit makes slot 1 the oldest
        queue_lookup(32'h8000_0000, 1'b0);
        for (int i = 2; i < TBL_SLOTS; i++)
            queue_lookup(32'h5A5A_0000 + i, 1'b1);
        queue_lookup(32'h7FFF_FFFF, 1'b1);    // full table: evicts key 1
        queue_lookup(32'h0000_0001, 1'b0);    // evicted key now misses
        queue_lookup('0, 1'b1);               // zero key on a full table
        queue_lookup(32'hFFFF_FFFF, 1'b1);    // hit with create set: no allocation

        // random: working set from a key pool whose span drifts around the
        // slot count, plus fresh keys and zero keys as noise
        key_pool[0] = 32'h0000_0001;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h7FFF_FFFF;
        for (int i = 4; i < POOL; i++)
            key_pool[i] = fresh_key();
        span = POOL - 1;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 50 == 0)
                span = $urandom_range(10, POOL - 1);
            if ($urandom_range(0, 15) == 0)
                key_pool[$urandom_range(0, POOL - 1)] = fresh_key();
            sel = $urandom_range(0, 19);
            if (sel == 0)
                queue_lookup('0, 1'($urandom_range(0, 1)));
            else if (sel <= 2)
                queue_lookup(fresh_key(), 1'($urandom_range(0, 1)));
            else
                queue_lookup(key_pool[$urandom_range(0, span)], $urandom_range(0, 3) != 0);
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_lookups.size() != 0 || i_valid)
            @(posedge i_clk);
        while (expected_slots.size() != 0)
            @(posedge i_clk);
        repeat (4 * LATENCY) @(posedge i_clk);

        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
